[rtl/eec_pkg.sv]
// ----------------------------------------------------------------------------
// eec_pkg: shared types and constants of the elastic easing curve core
// Number formats, request codes, the quarter-wave sine table and the
// per-term reciprocal constants of the exp2 Horner chain.
// ----------------------------------------------------------------------------
`default_nettype none

package eec_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int ONE          = 1 << FRAC_BITS;
  localparam int SINE_DEPTH   = 1024;
  localparam int INTERP_BITS  = 8;
  localparam int IDX_W        = $clog2(SINE_DEPTH);
  localparam int QUART        = SINE_DEPTH / 4;
  localparam int QIDX_W       = IDX_W - 1;
  localparam int PH_W         = IDX_W + INTERP_BITS;
  localparam int HORNER_TERMS = 12;
  localparam int OUT_W        = 19;

  // The angle product u*k is in units of 1/(4096*ONE) turn per third of a turn.
  localparam int ANG_W  = 36;
  localparam int ANG_LO = 12 + FRAC_BITS;
  localparam int W_W    = 4 + PH_W;

  localparam logic [1:0] REQ_IN    = 2'd0;
  localparam logic [1:0] REQ_OUT   = 2'd1;
  localparam logic [1:0] REQ_INOUT = 2'd2;

  localparam logic [14:0] FACTOR_RESET = 15'd8192;

  localparam int U_IN_OFS    = (43 * ONE) / 4;
  localparam int U_OUT_OFS   = (3 * ONE) / 4;
  localparam int U_INOUT_OFS = (89 * ONE) / 8;

  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // Reciprocals for the turn reduction (divide by 6 or 9).
  localparam logic [10:0] MOD_RCP_6 = 11'd1366;
  localparam logic [10:0] MOD_RCP_9 = 11'd911;
  localparam int          MOD_SH    = 13;
  localparam logic [23:0] PH_RCP_6  = 24'd11184811;
  localparam logic [23:0] PH_RCP_9  = 24'd7456541;
  localparam int          PH_SH     = 26;

  typedef logic [31:0] sine_tab_t [QUART+1];

  typedef struct packed {
    logic                     spec;
    logic                     spec_one;
    logic                     neg;
    logic                     off;
    logic                     half;
    logic [3:0]               n;
    logic [FRAC_BITS-1:0]     g;
    logic signed [20:0]       u;
    logic [29:0]              y;
    logic signed [ANG_W-1:0]  ang;
    logic [31:0]              mant;
    logic [W_W-1:0]           w;
    logic [PH_W-1:0]          ph;
    logic signed [32:0]       s0;
    logic signed [32:0]       s1;
    logic signed [43:0]       acc;
    logic signed [32:0]       sm;
    logic signed [63:0]       prod;
    logic [17:0]              mag;
    logic                     sgn;
  } ctx_t;

  function automatic longint unsigned mulq(input longint unsigned a,
                                           input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // Quarter-wave table: entry m is sin(m/QUART * pi/2) in Q30, from an
  // 11th-order Taylor series evaluated in integer Horner form.
  function automatic sine_tab_t build_sine();
    sine_tab_t        tab;
    longint unsigned  x;
    longint unsigned  x2;
    longint unsigned  t;
    longint unsigned  unit;
    unit = 64'd1 << 30;
    for (int m = 0; m <= QUART; m++) begin
      x  = (longint'(m) * PI_HALF_Q30) / QUART;
      x2 = mulq(x, x);
      t  = unit;
      t  = unit - mulq(x2, t) / 110;
      t  = unit - mulq(x2, t) / 72;
      t  = unit - mulq(x2, t) / 42;
      t  = unit - mulq(x2, t) / 20;
      t  = unit - mulq(x2, t) / 6;
      tab[m] = 32'(mulq(x, t));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // Full-wave entry by quadrant folding of the quarter table.
  function automatic logic signed [32:0] sine_lookup(input logic [IDX_W-1:0] idx);
    logic [QIDX_W-1:0]  m;
    logic signed [32:0] v;
    m = idx[IDX_W-2] ? (QIDX_W'(QUART) - {1'b0, idx[IDX_W-3:0]})
                     : {1'b0, idx[IDX_W-3:0]};
    v = $signed({1'b0, SINE_TAB[m]});
    return idx[IDX_W-1] ? -v : v;
  endfunction

  // floor(v/k) = (v*M) >> S, exact for v below 2^31.
  function automatic logic [31:0] div_mul(input int k);
    case (k)
      12:      return 32'd2863311531;
      11:      return 32'd3123612579;
      10:      return 32'd3435973837;
      9:       return 32'd3817748708;
      7:       return 32'd2454267027;
      6:       return 32'd2863311531;
      5:       return 32'd3435973837;
      3:       return 32'd2863311531;
      default: return 32'd1;
    endcase
  endfunction

  function automatic logic [5:0] div_sh(input int k);
    case (k)
      12, 11, 10, 9: return 6'd35;
      8:             return 6'd3;
      7, 6, 5:       return 6'd34;
      4:             return 6'd2;
      3:             return 6'd33;
      2:             return 6'd1;
      default:       return 6'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/eec_if.sv]
// ----------------------------------------------------------------------------
// eec_if: word channels of the elastic easing curve core
// Request channel (type and position) and result channel (eased value).
// ----------------------------------------------------------------------------
`default_nettype none

interface eec_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [16:0] position;
  modport source (output valid, req_type, position, input ready);
  modport sink (input valid, req_type, position, output ready);
endinterface

interface eec_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [eec_pkg::OUT_W-1:0] eased_value;
  modport source (output valid, eased_value, input ready);
  modport sink (input valid, eased_value, output ready);
endinterface

`default_nettype wire

[rtl/eec_front.sv]
// ----------------------------------------------------------------------------
// eec_front: request decode
// Derives the exponent split (n, g), the sine argument u and the special
// cases, then the exp2 series argument y and the angle product u*k.
// ----------------------------------------------------------------------------
`default_nettype none

module eec_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [1:0]    req_type,
  input  logic [16:0]   position,
  input  logic [14:0]   factor,
  output logic          out_vld,
  output eec_pkg::ctx_t out_ctx
);

  eec_pkg::ctx_t c1_nxt, c1_r, c2_nxt, c2_r;
  logic          v1_r, v2_r;

  logic [15:0]        x16;
  logic [19:0]        ten_x;
  logic [20:0]        twenty_x;
  logic [19:0]        neg_e;
  logic signed [21:0] u_wide;
  logic signed [35:0] u_ext;
  logic signed [35:0] k_ext;
  logic [45:0]        y_prod;

  always_comb begin
    c1_nxt   = '0;
    x16      = position[15:0];
    ten_x    = 20'(x16) * 20'd10;
    twenty_x = 21'(x16) * 21'd20;
    neg_e    = '0;
    u_wide   = '0;
    case (req_type)
      eec_pkg::REQ_IN: begin
        neg_e      = 20'(10 * eec_pkg::ONE) - ten_x;
        u_wide     = $signed({2'b0, ten_x}) - 22'(eec_pkg::U_IN_OFS);
        c1_nxt.neg = 1'b1;
      end
      eec_pkg::REQ_OUT: begin
        neg_e      = ten_x;
        u_wide     = $signed({2'b0, ten_x}) - 22'(eec_pkg::U_OUT_OFS);
        c1_nxt.off = 1'b1;
      end
      eec_pkg::REQ_INOUT: begin
        u_wide      = $signed({1'b0, twenty_x}) - 22'(eec_pkg::U_INOUT_OFS);
        c1_nxt.half = 1'b1;
        if (!x16[15]) begin
          neg_e      = 20'(10 * eec_pkg::ONE) - twenty_x[19:0];
          c1_nxt.neg = 1'b1;
        end else begin
          neg_e      = 20'(twenty_x - 21'(10 * eec_pkg::ONE));
          c1_nxt.off = 1'b1;
        end
      end
      default: begin
        c1_nxt.spec = 1'b1;
      end
    endcase
    if (position == '0) begin
      c1_nxt.spec     = 1'b1;
      c1_nxt.spec_one = 1'b0;
    end else if (position >= 17'(eec_pkg::ONE)) begin
      c1_nxt.spec     = 1'b1;
      c1_nxt.spec_one = 1'b1;
    end
    c1_nxt.u = 21'(u_wide);
    // A partial unit of the exponent rounds n up and leaves g = 1 - fraction.
    c1_nxt.n = neg_e[19:16] + {3'b0, |neg_e[15:0]};
    c1_nxt.g = (neg_e[15:0] == '0) ? '0
                                   : 16'(17'(eec_pkg::ONE) - {1'b0, neg_e[15:0]});
  end

  always_comb begin
    c2_nxt      = c1_r;
    y_prod      = 46'(c1_r.g) * 46'(eec_pkg::LN2_Q30);
    c2_nxt.y    = 30'(y_prod >> eec_pkg::FRAC_BITS);
    u_ext       = c1_r.u;
    k_ext       = {21'b0, factor};
    c2_nxt.ang  = u_ext * k_ext;
    c2_nxt.mant = eec_pkg::Q30_ONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
    end
  end

  assign out_vld = v2_r;
  assign out_ctx = c2_r;

endmodule

`default_nettype wire

[rtl/eec_exp_step.sv]
// ----------------------------------------------------------------------------
// eec_exp_step: one term of the exp Horner series
// t' = 1 + ((y*t) >> 30) / k, with the division done by a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module eec_exp_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  eec_pkg::ctx_t in_ctx,
  input  logic [31:0]   div_m,
  input  logic [5:0]    div_s,
  output logic          out_vld,
  output eec_pkg::ctx_t out_ctx
);

  eec_pkg::ctx_t a_nxt, a_r, b_nxt, b_r;
  logic          va_r, vb_r;
  logic [61:0]   prod_a;
  logic [63:0]   prod_b;

  always_comb begin
    a_nxt      = in_ctx;
    prod_a     = 62'(in_ctx.y) * 62'(in_ctx.mant);
    a_nxt.mant = prod_a[61:30];
  end

  always_comb begin
    b_nxt      = a_r;
    prod_b     = 64'(a_r.mant) * 64'(div_m);
    b_nxt.mant = eec_pkg::Q30_ONE + 32'(prod_b >> div_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_vld;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  assign out_vld = vb_r;
  assign out_ctx = b_r;

endmodule

`default_nettype wire

[rtl/eec_sine.sv]
// ----------------------------------------------------------------------------
// eec_sine: sine of the oscillation angle
// Reduces the angle product modulo one turn, quantizes it to table steps,
// looks up two neighboring entries and interpolates between them.
// ----------------------------------------------------------------------------
`default_nettype none

module eec_sine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  eec_pkg::ctx_t in_ctx,
  output logic          out_vld,
  output eec_pkg::ctx_t out_ctx
);

  eec_pkg::ctx_t s1_nxt, s1_r, s2_nxt, s2_r, s3_nxt, s3_r;
  eec_pkg::ctx_t s4_nxt, s4_r, s5_nxt, s5_r;
  logic [4:0]    v_r;

  logic [8:0]                    hi_ofs;
  logic [19:0]                   rq;
  logic [3:0]                    dsz;
  logic [3:0]                    hm;
  logic [47:0]                   ph_prod;
  logic [eec_pkg::IDX_W-1:0]     idx;
  logic [eec_pkg::IDX_W-1:0]     idx_n;
  logic [8:0]                    wt0;
  logic signed [43:0]            a0, a1, m0, m1;
  logic signed [43:0]            acc_adj;

  // Turn reduction: the high part of the product is taken modulo 6 or 9
  // (offset by 144 to stay positive), the low part passes through.
  always_comb begin
    s1_nxt = in_ctx;
    hi_ofs = 9'($signed(in_ctx.ang[eec_pkg::ANG_W-1:eec_pkg::ANG_LO])) + 9'd144;
    dsz    = in_ctx.half ? 4'd9 : 4'd6;
    rq     = (20'(hi_ofs) * 20'(in_ctx.half ? eec_pkg::MOD_RCP_9 : eec_pkg::MOD_RCP_6))
             >> eec_pkg::MOD_SH;
    hm     = 4'(20'(hi_ofs) - rq * 20'(dsz));
    s1_nxt.w = {hm, in_ctx.ang[eec_pkg::ANG_LO-1:eec_pkg::ANG_LO-eec_pkg::PH_W]};
  end

  always_comb begin
    s2_nxt    = s1_r;
    ph_prod   = 48'(s1_r.w) * 48'(s1_r.half ? eec_pkg::PH_RCP_9 : eec_pkg::PH_RCP_6);
    s2_nxt.ph = eec_pkg::PH_W'(ph_prod >> eec_pkg::PH_SH);
  end

  always_comb begin
    s3_nxt    = s2_r;
    idx       = s2_r.ph[eec_pkg::PH_W-1:eec_pkg::INTERP_BITS];
    idx_n     = eec_pkg::IDX_W'(idx + 1'b1);
    s3_nxt.s0 = eec_pkg::sine_lookup(idx);
    s3_nxt.s1 = eec_pkg::sine_lookup(idx_n);
  end

  always_comb begin
    s4_nxt     = s3_r;
    wt0        = 9'd256 - {1'b0, s3_r.ph[eec_pkg::INTERP_BITS-1:0]};
    a0         = s3_r.s0;
    a1         = s3_r.s1;
    m0         = {35'b0, wt0};
    m1         = {36'b0, s3_r.ph[eec_pkg::INTERP_BITS-1:0]};
    s4_nxt.acc = a0 * m0 + a1 * m1;
  end

  // Interpolated value is truncated toward zero.
  always_comb begin
    s5_nxt    = s4_r;
    acc_adj   = s4_r.acc + (s4_r.acc[43] ? 44'sd255 : 44'sd0);
    s5_nxt.sm = 33'(acc_adj >>> eec_pkg::INTERP_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
    end
  end

  assign out_vld = v_r[4];
  assign out_ctx = s5_r;

endmodule

`default_nettype wire

[rtl/eec_back.sv]
// ----------------------------------------------------------------------------
// eec_back: product, scaling and output register
// Multiplies the exp2 mantissa by the sine, scales with rounding half away
// from zero, applies sign, offset and the special cases and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module eec_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  eec_pkg::ctx_t                    in_ctx,
  output logic                             out_vld,
  output logic signed [eec_pkg::OUT_W-1:0] eased_value
);

  eec_pkg::ctx_t b1_nxt, b1_r, b2_nxt, b2_r;
  logic [1:0]    v_r;
  logic          res_vld_r;
  logic signed [eec_pkg::OUT_W-1:0] res_nxt, res_r;

  logic signed [63:0] m_ext, s_ext;
  logic [63:0]        mag;
  logic [5:0]         sh;
  logic [63:0]        rnd;
  logic signed [eec_pkg::OUT_W-1:0] val;

  always_comb begin
    b1_nxt      = in_ctx;
    m_ext       = {32'b0, in_ctx.mant};
    s_ext       = in_ctx.sm;
    b1_nxt.prod = m_ext * s_ext;
  end

  always_comb begin
    b2_nxt     = b1_r;
    mag        = b1_r.prod[63] ? 64'(-b1_r.prod) : 64'(b1_r.prod);
    sh         = 6'(60 - eec_pkg::FRAC_BITS) + {2'b0, b1_r.n} + {5'b0, b1_r.half};
    rnd        = mag + (64'd1 << (sh - 6'd1));
    b2_nxt.mag = 18'(rnd >> sh);
    b2_nxt.sgn = b1_r.prod[63];
  end

  always_comb begin
    val = b2_r.sgn ? -$signed({1'b0, b2_r.mag}) : $signed({1'b0, b2_r.mag});
    if (b2_r.neg) begin
      val = -val;
    end
    if (b2_r.off) begin
      val = val + eec_pkg::OUT_W'(eec_pkg::ONE);
    end
    res_nxt = val;
    if (b2_r.spec) begin
      res_nxt = b2_r.spec_one ? eec_pkg::OUT_W'(eec_pkg::ONE) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      res_vld_r <= 1'b0;
    end else if (en) begin
      v_r       <= {v_r[0], in_vld};
      res_vld_r <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_r  <= b1_nxt;
      b2_r  <= b2_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_vld     = res_vld_r;
  assign eased_value = res_r;

endmodule

`default_nettype wire

[rtl/elastic_easing_curve_core.sv]
// ----------------------------------------------------------------------------
// elastic_easing_curve_core: elastic in, out and in-out easing evaluator
// Top level: configuration register, pipeline control and the stage chain.
// ----------------------------------------------------------------------------
// Usage:
// A request word (req_type, position) enters on in_if; one result word
// (eased_value) leaves on out_if for every request, in request order.
// Positions use 65536 for 1.0; position 0 gives 0 and 1.0 or more gives 1.0.
// The oscillation factor k is written through cfg_we/cfg_wdata; the user
// must do so only while the core is idle, which the core does not enforce.
// k resets to 2.0 (8192). The path from acceptance to a valid result has
// 2 decode stages, 24 stages of the exp2 series (12 terms of two multiplies
// each), 5 sine stages and 3 output stages.
// Throughput is one word per cycle while the output is not stalled.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_if.ready drops; nothing is lost or repeated. Words in flight behind
// empty stages keep moving whenever the output register is free.
// Reset clears all valid bits and restores k; the core is ready next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module elastic_easing_curve_core (
  input  logic        clk,
  input  logic        rst_n,
  eec_in_if.sink      in_if,
  eec_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata
);

  logic [14:0]   k_r;
  logic          adv;
  logic          res_vld;
  logic signed [eec_pkg::OUT_W-1:0] res_val;

  eec_pkg::ctx_t exp_ctx [eec_pkg::HORNER_TERMS+1];
  logic          exp_vld [eec_pkg::HORNER_TERMS+1];
  eec_pkg::ctx_t sin_ctx;
  logic          sin_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= eec_pkg::FACTOR_RESET;
    end else if (cfg_we) begin
      k_r <= cfg_wdata;
    end
  end

  // The chain moves whenever the output register is empty or being taken.
  assign adv         = !res_vld || out_if.ready;
  assign in_if.ready = adv;

  eec_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (in_if.valid),
    .req_type (in_if.req_type),
    .position (in_if.position),
    .factor   (k_r),
    .out_vld  (exp_vld[0]),
    .out_ctx  (exp_ctx[0])
  );

  for (genvar i = 0; i < eec_pkg::HORNER_TERMS; i++) begin : g_exp
    eec_exp_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .in_vld  (exp_vld[i]),
      .in_ctx  (exp_ctx[i]),
      .div_m   (eec_pkg::div_mul(eec_pkg::HORNER_TERMS - i)),
      .div_s   (eec_pkg::div_sh(eec_pkg::HORNER_TERMS - i)),
      .out_vld (exp_vld[i+1]),
      .out_ctx (exp_ctx[i+1])
    );
  end

  eec_sine u_sine (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (exp_vld[eec_pkg::HORNER_TERMS]),
    .in_ctx  (exp_ctx[eec_pkg::HORNER_TERMS]),
    .out_vld (sin_vld),
    .out_ctx (sin_ctx)
  );

  eec_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_vld      (sin_vld),
    .in_ctx      (sin_ctx),
    .out_vld     (res_vld),
    .eased_value (res_val)
  );

  assign out_if.valid       = res_vld;
  assign out_if.eased_value = res_val;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_if.valid)
    else $error("result valid right after reset");

  a_reset_factor: assert property (@(posedge clk)
    !rst_n |=> (k_r == eec_pkg::FACTOR_RESET))
    else $error("frequency factor not restored by reset");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.eased_value >= -19'sd65536) &&
                     (out_if.eased_value <= 19'sd131072))
    else $error("eased value outside the curve range");

endmodule

`default_nettype wire
